@@ src/bfi_pkg.sv @@
// ----------------------------------------------------------------------------
// bfi_pkg
// shared types, codes and defaults for the brainfuck interpreter core
// ----------------------------------------------------------------------------
package bfi_pkg;

    localparam int unsigned PROG_DEPTH_DEF = 4096;
    localparam int unsigned TAPE_DEPTH_DEF = 1024;

    localparam int unsigned KIND_W   = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 24;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_LOADED  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_OUT     = 4'd1;
    localparam logic [KIND_W-1:0] KIND_NEED    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_HALT    = 4'd3;
    localparam logic [KIND_W-1:0] KIND_BRACKET = 4'd4;
    localparam logic [KIND_W-1:0] KIND_TAPE    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_FULL    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_ORDER   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_LIMIT   = 4'd8;

    // command opcodes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_SUPPLY = 2'd2;
    localparam logic [1:0] OP_CONT   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TAPE_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS  = 1'd1;

    localparam logic [9:0]  TAPE_START_RST = 10'd512;
    localparam logic [23:0] STEP_MAX       = 24'hFFFFFF;

    // program characters
    localparam logic [7:0] CH_RIGHT = 8'h3E; // >
    localparam logic [7:0] CH_LEFT  = 8'h3C; // <
    localparam logic [7:0] CH_INC   = 8'h2B; // +
    localparam logic [7:0] CH_DEC   = 8'h2D; // -
    localparam logic [7:0] CH_OUT   = 8'h2E; // .
    localparam logic [7:0] CH_IN    = 8'h2C; // ,
    localparam logic [7:0] CH_OPEN  = 8'h5B; // [
    localparam logic [7:0] CH_CLOSE = 8'h5D; // ]

    typedef enum logic [1:0] {
        RUN_IDLE    = 2'd0,
        RUN_WAIT_IN = 2'd1,
        RUN_WAIT_GO = 2'd2
    } t_run;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_FETCH,
        S_EXEC,
        S_TRD,
        S_SF_RD,
        S_SF_CK,
        S_SB_RD,
        S_SB_CK
    } t_state;

endpackage

@@ src/brainfuck_interpreter_core.sv @@
// ----------------------------------------------------------------------------
// brainfuck_interpreter_core
// loads a program into a program store and runs it on a byte tape
// ----------------------------------------------------------------------------
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+----------------------------------
//  command   | start / busy (beat: start&!busy) | i_opcode, i_data_byte, i_first_byte
//  result    | o_done strobe, one cycle      | o_kind, o_out_byte, o_program_length
//  config    | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
//  a load beat answers in the next cycle; a start with a valid tape start
//  first clears the tape, then runs
//  each executed instruction passes through fetch and execute states via the single
//  registered program store read port; pointer moves add a tape read state
//  a taken bracket walks the program store one character at a time, read then check
//  reset (i_rst_n low, synchronous) sets the program length to zero and idles the run;
//  the result receiver cannot stall, busy stays high until the result beat
//
module brainfuck_interpreter_core
    import bfi_pkg::*;
#(
    parameter int unsigned PROG_DEPTH = PROG_DEPTH_DEF,
    parameter int unsigned TAPE_DEPTH = TAPE_DEPTH_DEF,
    localparam int unsigned LW = $clog2(PROG_DEPTH + 1),
    localparam int unsigned AW = $clog2(PROG_DEPTH),
    localparam int unsigned TW = $clog2(TAPE_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_opcode,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_first_byte,
    output logic                 o_done,
    output logic [KIND_W-1:0]    o_kind,
    output logic [7:0]           o_out_byte,
    output logic [LW-1:0]        o_program_length,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // storage
    logic [7:0] prog_mem [PROG_DEPTH];
    logic [7:0] tape_mem [TAPE_DEPTH];
    logic [7:0] r_prog_q;
    logic [7:0] r_tape_q;

    // control and datapath registers
    t_state      r_state, n_state;
    t_run        r_run, n_run;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_pc, n_pc;
    logic [LW-1:0] r_scan, n_scan;       // bracket walk address
    logic [LW:0]   r_depth, n_depth;     // bracket nesting
    logic [TW-1:0] r_dp, n_dp;
    logic [TW-1:0] r_clr, n_clr;
    logic [7:0]    r_cell, n_cell;       // mirror of tape at the data pointer
    logic [23:0]   r_steps, n_steps;
    logic [9:0]    r_tape_start, n_tape_start;
    logic [23:0]   r_max_steps, n_max_steps;
    logic          r_done, n_done;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [7:0]    r_obyte, n_obyte;

    // memory port controls
    logic          prog_we;
    logic [AW-1:0] prog_waddr;
    logic [AW-1:0] prog_raddr;
    logic          tape_we;
    logic [TW-1:0] tape_waddr;
    logic [7:0]    tape_wdata;

    logic          accept;
    logic [LW-1:0] eff_len;
    logic [23:0]   limit;
    logic          start_bad;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_kind      = r_kind;
    assign o_out_byte  = r_obyte;
    assign o_program_length = r_len;

    assign eff_len   = i_first_byte ? '0 : r_len;
    assign limit     = (r_max_steps == '0) ? STEP_MAX : r_max_steps;
    assign start_bad = ({22'd0, r_tape_start} >= 32'(TAPE_DEPTH));

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (prog_we) begin
            prog_mem[prog_waddr] <= i_data_byte;
        end
        r_prog_q <= prog_mem[prog_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tape_we) begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        r_tape_q <= tape_mem[n_dp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_run        <= RUN_IDLE;
            r_len        <= '0;
            r_pc         <= '0;
            r_steps      <= '0;
            r_dp         <= TW'({22'd0, TAPE_START_RST});
            r_tape_start <= TAPE_START_RST;
            r_max_steps  <= '0;
            r_done       <= 1'b0;
            r_kind       <= KIND_LOADED;
            r_obyte      <= '0;
        end else begin
            r_state      <= n_state;
            r_run        <= n_run;
            r_len        <= n_len;
            r_pc         <= n_pc;
            r_steps      <= n_steps;
            r_dp         <= n_dp;
            r_tape_start <= n_tape_start;
            r_max_steps  <= n_max_steps;
            r_done       <= n_done;
            r_kind       <= n_kind;
            r_obyte      <= n_obyte;
        end
    end

    // datapath registers with no reset
    always_ff @(posedge i_clk) begin
        r_scan  <= n_scan;
        r_depth <= n_depth;
        r_clr   <= n_clr;
        r_cell  <= n_cell;
    end

    always_comb begin
        n_state      = r_state;
        n_run        = r_run;
        n_len        = r_len;
        n_pc         = r_pc;
        n_scan       = r_scan;
        n_depth      = r_depth;
        n_dp         = r_dp;
        n_clr        = r_clr;
        n_cell       = r_cell;
        n_steps      = r_steps;
        n_tape_start = r_tape_start;
        n_max_steps  = r_max_steps;
        n_done       = 1'b0;
        n_kind       = r_kind;
        n_obyte      = r_obyte;
        prog_we      = 1'b0;
        prog_waddr   = eff_len[AW-1:0];
        prog_raddr   = r_pc[AW-1:0];
        tape_we      = 1'b0;
        tape_waddr   = r_dp;
        tape_wdata   = r_cell;

        // the user must send config beats only while idle; the core does not enforce it
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TAPE_START: n_tape_start = i_cfg_data[9:0];
                REG_MAX_STEPS:  n_max_steps  = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_obyte = '0;
                    unique case (i_opcode)
                        OP_LOAD: begin
                            n_run  = RUN_IDLE;
                            n_done = 1'b1;
                            if (eff_len == LW'(PROG_DEPTH)) begin
                                n_len  = eff_len;
                                n_kind = KIND_FULL;
                            end else begin
                                prog_we = 1'b1;
                                n_len   = eff_len + 1'b1;
                                n_kind  = KIND_LOADED;
                            end
                        end
                        OP_START: begin
                            n_pc    = '0;
                            n_steps = '0;
                            if (start_bad) begin
                                n_dp   = '0;
                                n_run  = RUN_IDLE;
                                n_done = 1'b1;
                                n_kind = KIND_TAPE;
                            end else begin
                                n_dp    = TW'({22'd0, r_tape_start});
                                n_clr   = '0;
                                n_state = S_CLEAR;
                            end
                        end
                        OP_SUPPLY: begin
                            if (r_run != RUN_WAIT_IN) begin
                                n_done = 1'b1;
                                n_kind = KIND_ORDER;
                            end else begin
                                tape_we    = 1'b1;
                                tape_wdata = i_data_byte;
                                n_cell     = i_data_byte;
                                n_pc       = r_pc + 1'b1;
                                n_run      = RUN_IDLE;
                                n_state    = S_FETCH;
                            end
                        end
                        default: begin
                            if (r_run != RUN_WAIT_GO) begin
                                n_done = 1'b1;
                                n_kind = KIND_ORDER;
                            end else begin
                                n_run   = RUN_IDLE;
                                n_state = S_FETCH;
                            end
                        end
                    endcase
                end
            end

            // zero the tape, one cell a cycle
            S_CLEAR: begin
                tape_we    = 1'b1;
                tape_waddr = r_clr;
                tape_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == TW'(TAPE_DEPTH - 1)) begin
                    n_cell  = '0;
                    n_state = S_FETCH;
                end
            end

            S_FETCH: begin
                if (r_pc >= r_len) begin
                    n_run   = RUN_IDLE;
                    n_done  = 1'b1;
                    n_kind  = KIND_HALT;
                    n_state = S_IDLE;
                end else if (r_steps >= limit) begin
                    n_run   = RUN_IDLE;
                    n_done  = 1'b1;
                    n_kind  = KIND_LIMIT;
                    n_state = S_IDLE;
                end else begin
                    n_steps = r_steps + 1'b1;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_pc    = r_pc + 1'b1;
                n_state = S_FETCH;
                case (r_prog_q)
                    CH_RIGHT: begin
                        if (r_dp == TW'(TAPE_DEPTH - 1)) begin
                            n_pc    = r_pc;
                            n_run   = RUN_IDLE;
                            n_done  = 1'b1;
                            n_kind  = KIND_TAPE;
                            n_state = S_IDLE;
                        end else begin
                            n_dp    = r_dp + 1'b1;
                            n_state = S_TRD;
                        end
                    end
                    CH_LEFT: begin
                        if (r_dp == '0) begin
                            n_pc    = r_pc;
                            n_run   = RUN_IDLE;
                            n_done  = 1'b1;
                            n_kind  = KIND_TAPE;
                            n_state = S_IDLE;
                        end else begin
                            n_dp    = r_dp - 1'b1;
                            n_state = S_TRD;
                        end
                    end
                    CH_INC: begin
                        n_cell     = r_cell + 1'b1;
                        tape_we    = 1'b1;
                        tape_wdata = n_cell;
                    end
                    CH_DEC: begin
                        n_cell     = r_cell - 1'b1;
                        tape_we    = 1'b1;
                        tape_wdata = n_cell;
                    end
                    CH_IN: begin
                        n_pc    = r_pc;
                        n_run   = RUN_WAIT_IN;
                        n_done  = 1'b1;
                        n_kind  = KIND_NEED;
                        n_state = S_IDLE;
                    end
                    CH_OUT: begin
                        n_run   = RUN_WAIT_GO;
                        n_done  = 1'b1;
                        n_kind  = KIND_OUT;
                        n_obyte = r_cell;
                        n_state = S_IDLE;
                    end
                    CH_OPEN: begin
                        if (r_cell == '0) begin
                            n_pc    = r_pc;
                            n_scan  = r_pc + 1'b1;
                            n_depth = (LW+1)'(1);
                            n_state = S_SF_RD;
                        end
                    end
                    CH_CLOSE: begin
                        if (r_cell != '0) begin
                            n_pc    = r_pc;
                            n_scan  = r_pc;
                            n_depth = (LW+1)'(1);
                            n_state = S_SB_RD;
                        end
                    end
                    default: ;
                endcase
            end

            // new data pointer: pick up its cell
            S_TRD: begin
                n_cell  = r_tape_q;
                n_state = S_FETCH;
            end

            // forward walk to the matching close bracket
            S_SF_RD: begin
                prog_raddr = r_scan[AW-1:0];
                if (r_scan >= r_len) begin
                    n_run   = RUN_IDLE;
                    n_done  = 1'b1;
                    n_kind  = KIND_BRACKET;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SF_CK;
                end
            end

            S_SF_CK: begin
                n_state = S_SF_RD;
                n_scan  = r_scan + 1'b1;
                if (r_prog_q == CH_OPEN) begin
                    n_depth = r_depth + 1'b1;
                end else if (r_prog_q == CH_CLOSE) begin
                    n_depth = r_depth - 1'b1;
                    if (r_depth == (LW+1)'(1)) begin
                        n_pc    = r_scan + 1'b1;
                        n_state = S_FETCH;
                    end
                end
            end

            // backward walk to the matching open bracket
            S_SB_RD: begin
                prog_raddr = AW'(r_scan - 1'b1);
                if (r_scan == '0) begin
                    n_run   = RUN_IDLE;
                    n_done  = 1'b1;
                    n_kind  = KIND_BRACKET;
                    n_state = S_IDLE;
                end else begin
                    n_scan  = r_scan - 1'b1;
                    n_state = S_SB_CK;
                end
            end

            S_SB_CK: begin
                n_state = S_SB_RD;
                if (r_prog_q == CH_CLOSE) begin
                    n_depth = r_depth + 1'b1;
                end else if (r_prog_q == CH_OPEN) begin
                    n_depth = r_depth - 1'b1;
                    if (r_depth == (LW+1)'(1)) begin
                        n_pc    = r_scan + 1'b1;
                        n_state = S_FETCH;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ src/bfi_checker.sv @@
// ----------------------------------------------------------------------------
// bfi_checker
// port-level checks on the interpreter core, bound to the top level
// ----------------------------------------------------------------------------
module bfi_checker
    import bfi_pkg::*;
#(
    parameter int unsigned LW = 13
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic [1:0]           i_opcode,
    input logic [7:0]           i_data_byte,
    input logic                 i_first_byte,
    input logic                 o_done,
    input logic [KIND_W-1:0]    o_kind,
    input logic [7:0]           o_out_byte,
    input logic [LW-1:0]        o_program_length,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [CFG_DAT_W-1:0] i_cfg_data
);

    // a beat either answers next cycle or keeps the core busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("beat neither answered nor started work");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while busy");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_kind != KIND_OUT)) |-> (o_out_byte == 8'd0))
        else $error("out byte set on a non-output result");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_kind <= KIND_LIMIT))
        else $error("undefined result kind");

    a_len_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_program_length) |-> (o_done && ($past(i_opcode) == OP_LOAD)))
        else $error("program length moved without a load");

endmodule

bind brainfuck_interpreter_core bfi_checker #(.LW(LW)) u_bfi_checker (.*);
